[src/lpmd_pkg.sv]
// shared types and constants for the length-prefixed message deframer
package lpmd_pkg;

  localparam int unsigned MaxLenW     = 15;
  localparam int unsigned FieldW      = 16;
  localparam logic [MaxLenW-1:0] MaxLenReset = 15'd1024;

  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_PAYLOAD = 2'd1,
    PH_HALTED  = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_EMPTY   = 2'd1,
    KIND_ERROR   = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t             kind;
    logic [FieldW-1:0] message_id;
    logic [FieldW-1:0] message_len;
    logic [7:0]        payload_byte;
    logic              last;
  } res_t;

endpackage

[src/lpmd_ifs.sv]
// stream interfaces for received bytes and deframed results
interface lpmd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface lpmd_result_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [15:0] message_id;
  logic [15:0] message_len;
  logic [7:0]  payload_byte;
  logic        last;

  modport source (output valid, output kind, output message_id, output message_len,
                  output payload_byte, output last, input ready);
  modport sink   (input valid, input kind, input message_id, input message_len,
                  input payload_byte, input last, output ready);
endinterface

[src/lpmd_in_reg.sv]
// input register holding one received byte until the core takes it
module lpmd_in_reg (
  input  logic       clk,
  input  logic       rst,
  lpmd_byte_if.sink  rx,
  input  logic       take,
  output logic       held_valid,
  output logic [7:0] held_byte
);

  logic       held_valid_next;

  assign rx.ready = !held_valid || take;

  always_comb begin
    held_valid_next = held_valid;
    if (rx.ready) begin
      held_valid_next = rx.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else begin
      held_valid <= held_valid_next;
    end
    if (rx.ready && rx.valid) begin
      held_byte <= rx.rx_byte;
    end
  end

endmodule

[src/lpmd_core.sv]
// header parser, payload counter and length check
module lpmd_core (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_wr_en,
  input  logic [lpmd_pkg::MaxLenW-1:0] cfg_wr_data,
  input  logic                       step,
  input  logic [7:0]                 in_byte,
  output logic                       res_valid,
  output lpmd_pkg::res_t             res
);
  import lpmd_pkg::*;

  logic [MaxLenW-1:0] max_len;
  phase_t             phase, phase_next;
  logic [1:0]         header_count, header_count_next;
  logic [23:0]        header_bytes, header_bytes_next;
  logic [FieldW-1:0]  current_id, current_id_next;
  logic [FieldW-1:0]  current_len, current_len_next;
  logic [FieldW-1:0]  bytes_left, bytes_left_next;

  logic [FieldW-1:0]  hdr_id;
  logic [FieldW-1:0]  hdr_len;
  logic               len_bad;
  logic               hdr_done;
  logic [FieldW-1:0]  left_dec;
  logic               fin;

  assign hdr_id   = header_bytes[23:8];
  assign hdr_len  = {header_bytes[7:0], in_byte};
  assign len_bad  = hdr_len[FieldW-1] || (hdr_len[MaxLenW-1:0] > max_len);
  assign hdr_done = (header_count == 2'd3);
  assign left_dec = bytes_left - 16'd1;
  assign fin      = (left_dec == '0);

  // next state
  always_comb begin
    phase_next        = phase;
    header_count_next = header_count;
    header_bytes_next = header_bytes;
    current_id_next   = current_id;
    current_len_next  = current_len;
    bytes_left_next   = bytes_left;
    unique case (phase)
      PH_HEADER: begin
        if (!hdr_done) begin
          header_bytes_next = {header_bytes[15:0], in_byte};
          header_count_next = header_count + 2'd1;
        end else begin
          current_id_next   = hdr_id;
          current_len_next  = hdr_len;
          header_count_next = 2'd0;
          header_bytes_next = '0;
          if (len_bad) begin
            phase_next      = PH_HALTED;
            bytes_left_next = '0;
          end else if (hdr_len == '0) begin
            bytes_left_next = '0;
          end else begin
            bytes_left_next = hdr_len;
            phase_next      = PH_PAYLOAD;
          end
        end
      end
      PH_PAYLOAD: begin
        bytes_left_next = left_dec;
        if (fin) begin
          phase_next = PH_HEADER;
        end
      end
      default: begin
        phase_next = phase;
      end
    endcase
  end

  // result
  always_comb begin
    res_valid        = 1'b0;
    res.kind         = KIND_PAYLOAD;
    res.message_id   = current_id;
    res.message_len  = current_len;
    res.payload_byte = 8'd0;
    res.last         = 1'b0;
    unique case (phase)
      PH_HEADER: begin
        res.message_id  = hdr_id;
        res.message_len = hdr_len;
        if (hdr_done && len_bad) begin
          res_valid = 1'b1;
          res.kind  = KIND_ERROR;
          res.last  = 1'b1;
        end else if (hdr_done && (hdr_len == '0)) begin
          res_valid = 1'b1;
          res.kind  = KIND_EMPTY;
          res.last  = 1'b1;
        end
      end
      PH_PAYLOAD: begin
        res_valid        = 1'b1;
        res.kind         = KIND_PAYLOAD;
        res.payload_byte = in_byte;
        res.last         = fin;
      end
      default: begin
        res_valid = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_len      <= MaxLenReset;
      phase        <= PH_HEADER;
      header_count <= 2'd0;
      header_bytes <= '0;
      current_id   <= '0;
      current_len  <= '0;
      bytes_left   <= '0;
    end else begin
      if (cfg_wr_en) begin
        max_len <= cfg_wr_data;
      end
      if (step) begin
        phase        <= phase_next;
        header_count <= header_count_next;
        header_bytes <= header_bytes_next;
        current_id   <= current_id_next;
        current_len  <= current_len_next;
        bytes_left   <= bytes_left_next;
      end
    end
  end

endmodule

[src/lpmd_out_reg.sv]
// result register driving the outgoing channel
module lpmd_out_reg (
  input  logic           clk,
  input  logic           rst,
  input  logic           load,
  input  lpmd_pkg::res_t res,
  output logic           free,
  lpmd_result_if.source  tx
);
  import lpmd_pkg::*;

  logic out_valid;
  res_t held;

  assign free            = !out_valid || tx.ready;
  assign tx.valid        = out_valid;
  assign tx.kind         = held.kind;
  assign tx.message_id   = held.message_id;
  assign tx.message_len  = held.message_len;
  assign tx.payload_byte = held.payload_byte;
  assign tx.last         = held.last;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (free) begin
      out_valid <= load;
    end
    if (free && load) begin
      held <= res;
    end
  end

endmodule

[src/length_prefixed_message_deframer_top.sv]
// top level of the length-prefixed message deframer
//
//   channel  dir  payload                                              handshake
//   rx       in   rx_byte                                              valid/ready
//   tx       out  kind, message_id, message_len, payload_byte, last    valid/ready
//   cfg      in   cfg_wr_data (max_payload_len)                        cfg_wr_en
//
// one byte per cycle sustained while tx accepts; the rx byte passes through the input register,
// then parser logic into the result register, which drives tx valid
// rst is synchronous; max_payload_len returns to 1024 and the parser to header phase
// a stalled tx holds the result register and backs up rx through the input register
module length_prefixed_message_deframer_top (
  input  logic                         clk,
  input  logic                         rst,
  lpmd_byte_if.sink                    rx,
  lpmd_result_if.source                tx,
  input  logic                         cfg_wr_en,
  input  logic [lpmd_pkg::MaxLenW-1:0] cfg_wr_data
);
  import lpmd_pkg::*;

  logic       held_valid;
  logic [7:0] held_byte;
  logic       free;
  logic       step;
  logic       res_valid;
  res_t       res;

  assign step = held_valid && free;

  lpmd_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .rx         (rx),
    .take       (step),
    .held_valid (held_valid),
    .held_byte  (held_byte)
  );

  lpmd_core u_core (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .step        (step),
    .in_byte     (held_byte),
    .res_valid   (res_valid),
    .res         (res)
  );

  lpmd_out_reg u_out_reg (
    .clk  (clk),
    .rst  (rst),
    .load (step && res_valid),
    .res  (res),
    .free (free),
    .tx   (tx)
  );

endmodule

[tb/tb_length_prefixed_message_deframer_top.sv]
// testbench for the length-prefixed message deframer: directed and random byte streams
`timescale 1ns / 1ps

module tb_length_prefixed_message_deframer_top;
  import lpmd_pkg::*;

  logic clk;
  logic rst;
  logic cfg_wr_en;
  logic [MaxLenW-1:0] cfg_wr_data;

  lpmd_byte_if   rx_if ();
  lpmd_result_if tx_if ();

  length_prefixed_message_deframer_top dut (
    .clk         (clk),
    .rst         (rst),
    .rx          (rx_if),
    .tx          (tx_if),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  // deframer state mirrored on the testbench side
  phase_t              ph;
  logic [1:0]          hdr_cnt;
  logic [23:0]         hdr_bytes;
  logic [FieldW-1:0]   cur_id;
  logic [FieldW-1:0]   cur_len;
  logic [FieldW-1:0]   bytes_left;
  logic [MaxLenW-1:0]  max_len;

  res_t pending_results[$];
  int   mismatches;
  int   bytes_sent;
  bit   no_idle;
  int   stall_left;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  function automatic int pause_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 2);
    if (r < 95) return $urandom_range(3, 6);
    return $urandom_range(10, 30);
  endfunction

  function automatic void push_result(kind_t k, logic [7:0] b, logic fin);
    res_t r;
    r.kind         = k;
    r.message_id   = cur_id;
    r.message_len  = cur_len;
    r.payload_byte = b;
    r.last         = fin;
    pending_results.push_back(r);
  endfunction

  function automatic void deframe_byte(logic [7:0] b);
    case (ph)
      PH_HEADER: begin
        if (hdr_cnt != 2'd3) begin
          hdr_bytes = {hdr_bytes[15:0], b};
          hdr_cnt   = hdr_cnt + 2'd1;
        end else begin
          cur_id    = hdr_bytes[23:8];
          cur_len   = {hdr_bytes[7:0], b};
          hdr_cnt   = 2'd0;
          hdr_bytes = '0;
          bytes_left = '0;
          if (cur_len[15] || cur_len > {1'b0, max_len}) begin
            ph = PH_HALTED;
            push_result(KIND_ERROR, 8'h00, 1'b1);
          end else if (cur_len == '0) begin
            push_result(KIND_EMPTY, 8'h00, 1'b1);
          end else begin
            bytes_left = cur_len;
            ph = PH_PAYLOAD;
          end
        end
      end
      PH_PAYLOAD: begin
        bytes_left = bytes_left - 16'd1;
        if (bytes_left == '0) ph = PH_HEADER;
        push_result(KIND_PAYLOAD, b, bytes_left == '0);
      end
      default: begin
      end
    endcase
  endfunction

  // receiver side: random back-pressure, long stalls now and then
  always @(negedge clk) begin
    if (no_idle) begin
      tx_if.ready <= 1'b1;
    end else if (stall_left > 0) begin
      tx_if.ready <= 1'b0;
      stall_left = stall_left - 1;
    end else if ($urandom_range(0, 99) < 25) begin
      tx_if.ready <= 1'b0;
      stall_left = pause_len() - 1;
    end else begin
      tx_if.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin : check_results
    res_t want;
    if (!rst && tx_if.valid && tx_if.ready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected transaction: kind %0d id %0h len %0h byte %0h last %0b",
               tx_if.kind, tx_if.message_id, tx_if.message_len, tx_if.payload_byte,
               tx_if.last);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (tx_if.kind !== want.kind) begin
          $error("kind: expected %0d, got %0d", want.kind, tx_if.kind);
          mismatches++;
        end
        if (tx_if.message_id !== want.message_id) begin
          $error("message_id: expected %0h, got %0h", want.message_id, tx_if.message_id);
          mismatches++;
        end
        if (tx_if.message_len !== want.message_len) begin
          $error("message_len: expected %0h, got %0h", want.message_len, tx_if.message_len);
          mismatches++;
        end
        if (tx_if.payload_byte !== want.payload_byte) begin
          $error("payload_byte: expected %0h, got %0h", want.payload_byte,
                 tx_if.payload_byte);
          mismatches++;
        end
        if (tx_if.last !== want.last) begin
          $error("last: expected %0b, got %0b", want.last, tx_if.last);
          mismatches++;
        end
      end
    end
  end

  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = (no_idle || $urandom_range(0, 99) < 60) ? 0 : pause_len();
    @(negedge clk);
    if (gap > 0) begin
      rx_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    rx_if.valid   <= 1'b1;
    rx_if.rx_byte <= b;
    do @(posedge clk); while (!rx_if.ready);
    deframe_byte(b);
    bytes_sent++;
  endtask

  task automatic send_header(input logic [15:0] id, input logic [15:0] len);
    send_byte(id[15:8]);
    send_byte(id[7:0]);
    send_byte(len[15:8]);
    send_byte(len[7:0]);
  endtask

  task automatic send_message(input logic [15:0] id, input logic [15:0] len);
    send_header(id, len);
    repeat (len) send_byte(8'($urandom_range(0, 255)));
  endtask

  // drop valid and let every outstanding transaction drain
  task automatic settle();
    @(negedge clk);
    rx_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_max_len(input logic [MaxLenW-1:0] v);
    settle();
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    max_len = v;
  endtask

  task automatic test_directed();
    send_message(16'hFFFF, 16'd0);
    send_header(16'h0000, 16'd1);
    send_byte(8'h00);
    send_header(16'hA55A, 16'd2);
    send_byte(8'hFF);
    send_byte(8'h80);
    set_max_len(15'd3);
    send_header(16'h5AA5, 16'd3);
    send_byte(8'h01);
    send_byte(8'hFE);
    send_byte(8'h7F);
    set_max_len(15'd0);
    send_message(16'h0001, 16'd0);
    settle();
  endtask

  task automatic test_random_traffic(input logic [MaxLenW-1:0] limit, input int n,
                                     input bit quiet);
    int target;
    int r;
    int unsigned cap;
    int unsigned wide;
    logic [15:0] len;
    set_max_len(limit);
    no_idle = quiet;
    target  = bytes_sent + n;
    cap  = (limit < 16) ? limit : 16;
    wide = (limit < 200) ? limit : 200;
    while (bytes_sent < target) begin
      r = $urandom_range(0, 99);
      if (limit == 0 || r < 10) len = 16'd0;
      else if (r < 15) len = (limit <= 200) ? {1'b0, limit} : 16'(wide);
      else if (r < 92) len = 16'($urandom_range(1, cap));
      else len = 16'($urandom_range(1, wide));
      send_message(16'($urandom_range(0, 65535)), len);
      if ($urandom_range(0, 99) < 5) settle();
    end
    settle();
    no_idle = 1'b0;
  endtask

  // a bad length halts the parser for good, so this runs after all other traffic, just before test_halted
  task automatic test_bad_length();
    logic [MaxLenW-1:0] limit;
    logic [15:0] len;
    limit = 15'($urandom_range(6, 32766));
    set_max_len(limit);
    send_message(16'($urandom_range(0, 65535)), 16'($urandom_range(1, 6)));
    if ($urandom_range(0, 1) == 0) len = {1'b1, 15'($urandom_range(0, 32767))};
    else len = {1'b0, limit} + 16'd1;
    send_header(16'($urandom_range(0, 65535)), len);
    settle();
  endtask

  task automatic test_halted();
    repeat (20) send_byte(8'($urandom_range(0, 255)));
    send_header(16'h0000, 16'd0);
    settle();
  endtask

  initial begin
    rst           = 1'b1;
    cfg_wr_en     = 1'b0;
    cfg_wr_data   = '0;
    rx_if.valid   = 1'b0;
    rx_if.rx_byte = '0;
    tx_if.ready   = 1'b0;
    mismatches    = 0;
    bytes_sent    = 0;
    no_idle       = 1'b0;
    stall_left    = 0;
    ph            = PH_HEADER;
    hdr_cnt       = '0;
    hdr_bytes     = '0;
    cur_id        = '0;
    cur_len       = '0;
    bytes_left    = '0;
    max_len       = MaxLenReset;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed();
    test_random_traffic(15'd32767, 110, 1'b0);
    test_random_traffic(15'($urandom_range(1, 20)), 100, 1'b0);
    test_random_traffic(15'd1024, 90, 1'b1);
    test_random_traffic(15'd0, 30, 1'b0);
    test_random_traffic(15'($urandom_range(1, 32767)), 100, 1'b0);
    test_bad_length();
    test_halted();

    repeat (10) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
